// ===== src/m4vt_pkg.sv =====
// Shared types and constants of the 4x4 matrix-vector transform block.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package m4vt_pkg;

    localparam int LANES      = 4;
    localparam int ELEM_W     = 32;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int SUM_W      = PROD_W + 2;
    localparam int NUM_REGS   = 8;
    localparam int PAIR_IDX_W = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef t_elem t_vec4 [LANES];

    // Stage load enables handed from the top level to each lane.
    typedef struct packed {
        logic prod;
        logic pair;
        logic fin;
    } t_stage_en;

    // Reset contents of the matrix registers: the identity matrix in Q16.16.
    localparam logic [CFG_DATA_W-1:0] MAT_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

endpackage

`default_nettype wire

// ===== src/m4vt_if.sv =====
// Handshake channels of the transform block: request, result and register write.
// Depends on m4vt_pkg for field widths.
`default_nettype none

interface m4vt_in_if;
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    m4vt_pkg::t_elem       vec_x;
    m4vt_pkg::t_elem       vec_y;
    m4vt_pkg::t_elem       vec_z;
    m4vt_pkg::t_elem       vec_w;

    modport source (output valid, req_type, vec_x, vec_y, vec_z, vec_w, input ready);
    modport sink   (input valid, req_type, vec_x, vec_y, vec_z, vec_w, output ready);
endinterface

interface m4vt_out_if;
    logic                  valid;
    logic                  ready;
    m4vt_pkg::t_elem       out_x;
    m4vt_pkg::t_elem       out_y;
    m4vt_pkg::t_elem       out_z;
    m4vt_pkg::t_elem       out_w;
    logic                  overflow;

    modport source (output valid, out_x, out_y, out_z, out_w, overflow, input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_w, overflow, output ready);
endinterface

interface m4vt_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [m4vt_pkg::CFG_IDX_W-1:0]     reg_index;
    logic [m4vt_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, reg_index, data, input ready);
    modport sink   (input valid, reg_index, data, output ready);
endinterface

`default_nettype wire

// ===== src/m4vt_lane.sv =====
// One result lane: four signed products, a two-level adder tree, then the
// fixed-point shift and 32-bit saturation. Depends on m4vt_pkg.
`default_nettype none

module m4vt_lane #(
    parameter int FRAC_BITS = 16
) (
    input  wire                     i_clk,
    input  wire m4vt_pkg::t_stage_en i_en,
    input  wire m4vt_pkg::t_vec4    i_mat,
    input  wire m4vt_pkg::t_vec4    i_vec,
    output m4vt_pkg::t_elem         o_result,
    output logic                    o_ovf
);

    logic signed [m4vt_pkg::PROD_W-1:0] r_prod [m4vt_pkg::LANES];
    logic        [m4vt_pkg::PAIR_W-1:0] r_pair [2];
    m4vt_pkg::t_elem                    r_result;
    logic                               r_ovf;

    logic signed [m4vt_pkg::SUM_W-1:0]  w_sum;
    logic signed [m4vt_pkg::SUM_W-1:0]  w_shift;
    logic [m4vt_pkg::SUM_W-m4vt_pkg::ELEM_W:0] w_top;
    logic                               w_in_range;
    m4vt_pkg::t_elem                    n_result;

    always_ff @(posedge i_clk) begin
        if (i_en.prod) begin
            for (int k = 0; k < m4vt_pkg::LANES; k++) begin
                r_prod[k] <= i_mat[k] * i_vec[k];
            end
        end
        if (i_en.pair) begin
            r_pair[0] <= {r_prod[0][m4vt_pkg::PROD_W-1], r_prod[0]}
                       + {r_prod[1][m4vt_pkg::PROD_W-1], r_prod[1]};
            r_pair[1] <= {r_prod[2][m4vt_pkg::PROD_W-1], r_prod[2]}
                       + {r_prod[3][m4vt_pkg::PROD_W-1], r_prod[3]};
        end
        if (i_en.fin) begin
            r_result <= n_result;
            r_ovf    <= !w_in_range;
        end
    end

    always_comb begin
        w_sum   = $signed({r_pair[0][m4vt_pkg::PAIR_W-1], r_pair[0]}
                        + {r_pair[1][m4vt_pkg::PAIR_W-1], r_pair[1]});
        w_shift = w_sum >>> FRAC_BITS;
        // The shifted sum fits in 32 bits when its top bits are all sign copies.
        w_top      = w_shift[m4vt_pkg::SUM_W-1:m4vt_pkg::ELEM_W-1];
        w_in_range = (&w_top) || !(|w_top);
        if (w_in_range) begin
            n_result = w_shift[m4vt_pkg::ELEM_W-1:0];
        end else if (w_shift[m4vt_pkg::SUM_W-1]) begin
            n_result = 32'sh8000_0000;
        end else begin
            n_result = 32'sh7FFF_FFFF;
        end
    end

    assign o_result = r_result;
    assign o_ovf    = r_ovf;

endmodule

`default_nettype wire

// ===== src/mat4_vector_transform.sv =====
// Top level of the 4x4 matrix-vector transform: matrix registers, operand
// stage, four lanes and the pipeline control. Depends on m4vt_pkg, m4vt_if, m4vt_lane.
`default_nettype none

// Multiplies a signed Q16.16 vector by a 4x4 signed Q16.16 matrix held in
// eight 64-bit registers (element 2i in bits 31..0 and element 2i+1 in bits
// 63..32 of register i, row-major). A request beat with req_type 0 gives the
// matrix times the vector as a column; req_type 1 gives the vector as a row
// times the matrix, i.e. one row of a 4x4 matrix product. Each lane sums its
// four full-width products exactly, shifts right arithmetically by FRAC_BITS
// (rounding toward minus infinity) and saturates to 32 bits; overflow is set
// when any lane saturated. The pipeline has four register stages (operand
// select, multiply, pair add, final add with saturation), and a request beat
// passes through them in that order before its result beat is offered; a new
// request is taken in every cycle as long as results are taken; a stalled
// result holds the stages behind it, and empty stages still fill.
// The sixteen 32x32 multipliers set the stage depth.
// The register write port is always ready; writes to an index of eight or
// more are dropped. Registers reset to the identity matrix, and they should
// be written only while no request is in flight.

module mat4_vector_transform #(
    parameter int FRAC_BITS = 16
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    m4vt_in_if.sink         i_req,
    m4vt_cfg_if.sink        i_cfg,
    m4vt_out_if.source      o_res
);

    localparam int L = m4vt_pkg::LANES;

    // Matrix registers.
    logic [m4vt_pkg::CFG_DATA_W-1:0] r_mat_pair [m4vt_pkg::NUM_REGS];
    m4vt_pkg::t_elem                 w_elem [L*L];

    // Operand stage: per lane, the four matrix elements that meet the vector.
    m4vt_pkg::t_vec4                 r_a_mat [L];
    m4vt_pkg::t_vec4                 r_a_vec;

    // Valid bits travel beside the data of each stage.
    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic w_adv_a, w_adv_b, w_adv_c, w_adv_d;
    m4vt_pkg::t_stage_en w_en;

    m4vt_pkg::t_elem w_result [L];
    logic [L-1:0]    w_ovf;

    // Register writes. The port never pushes back.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < m4vt_pkg::NUM_REGS; i++) begin
                r_mat_pair[i] <= m4vt_pkg::MAT_RESET[i];
            end
        end else if (i_cfg.valid && i_cfg.ready
                     && (i_cfg.reg_index < m4vt_pkg::CFG_IDX_W'(m4vt_pkg::NUM_REGS))) begin
            r_mat_pair[i_cfg.reg_index[m4vt_pkg::PAIR_IDX_W-1:0]] <= i_cfg.data;
        end
    end

    // Unpack the registers into sixteen row-major elements.
    always_comb begin
        for (int e = 0; e < L*L; e++) begin
            w_elem[e] = r_mat_pair[e/2][(e%2)*m4vt_pkg::ELEM_W +: m4vt_pkg::ELEM_W];
        end
    end

    // Pipeline control: a stage moves when it is empty or the next one moves.
    assign w_adv_d  = !r_d_valid || o_res.ready;
    assign w_adv_c  = !r_c_valid || w_adv_d;
    assign w_adv_b  = !r_b_valid || w_adv_c;
    assign w_adv_a  = !r_a_valid || w_adv_b;
    assign i_req.ready = w_adv_a;

    assign w_en.prod = w_adv_b && r_a_valid;
    assign w_en.pair = w_adv_c && r_b_valid;
    assign w_en.fin  = w_adv_d && r_c_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (w_adv_a) begin
                r_a_valid <= i_req.valid;
            end
            if (w_adv_b) begin
                r_b_valid <= r_a_valid;
            end
            if (w_adv_c) begin
                r_c_valid <= r_b_valid;
            end
            if (w_adv_d) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    // Operand select: column mode pairs row "lane" with the vector, row mode
    // pairs column "lane" with it.
    always_ff @(posedge i_clk) begin
        if (w_adv_a && i_req.valid) begin
            r_a_vec[0] <= i_req.vec_x;
            r_a_vec[1] <= i_req.vec_y;
            r_a_vec[2] <= i_req.vec_z;
            r_a_vec[3] <= i_req.vec_w;
            for (int lane = 0; lane < L; lane++) begin
                for (int k = 0; k < L; k++) begin
                    r_a_mat[lane][k] <= i_req.req_type ? w_elem[L*k + lane]
                                                       : w_elem[L*lane + k];
                end
            end
        end
    end

    for (genvar g = 0; g < L; g++) begin : g_lane
        m4vt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_mat    (r_a_mat[g]),
            .i_vec    (r_a_vec),
            .o_result (w_result[g]),
            .o_ovf    (w_ovf[g])
        );
    end

    assign o_res.valid    = r_d_valid;
    assign o_res.out_x    = w_result[0];
    assign o_res.out_y    = w_result[1];
    assign o_res.out_z    = w_result[2];
    assign o_res.out_w    = w_result[3];
    assign o_res.overflow = |w_ovf;

`ifndef SYNTHESIS
    // A beat in the pair-add stage must not vanish while the output is stalled.
    a_hold_c : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid && r_d_valid && !o_res.ready |=> r_c_valid)
        else $error("pair-add stage lost a beat under stall");

    // An empty operand stage always lets a request in.
    a_ready_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_a_valid |-> i_req.ready)
        else $error("request refused with an empty operand stage");

    // A stalled result with the stages behind it full keeps the multiply stage frozen.
    a_no_drop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_c_valid && r_d_valid && !o_res.ready |=> r_b_valid)
        else $error("multiply stage lost a beat under stall");
`endif

endmodule

`default_nettype wire
